// ===== hdl/tha_pkg.sv =====
package tha_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;
    localparam int SQRT_STEPS        = 24;
    localparam int XY_W              = 28;
    localparam int ACC_W             = 27;
    localparam int ANG_W             = 19;

    localparam logic signed [ACC_W-1:0] DEG90_Q16  = ACC_W'(5898240);
    localparam logic signed [ANG_W-1:0] TILT_LIMIT = ANG_W'(23040);
    localparam logic signed [ANG_W-1:0] HEAD_LIMIT = ANG_W'(46080);

    typedef struct packed {
        logic [47:0] n;
        logic [26:0] rem;
        logic [23:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
    } cd_lane_t;

    typedef struct packed {
        sqrt_lane_t             pitch;
        sqrt_lane_t             roll;
        logic signed [15:0]     ax;
        logic signed [15:0]     ay;
        cd_lane_t               head;
        logic                   tilt_zero;
        logic                   head_zero;
    } sq_stage_t;

    typedef struct packed {
        cd_lane_t pitch;
        cd_lane_t roll;
        cd_lane_t head;
        logic     tilt_zero;
        logic     head_zero;
    } cd_stage_t;

    // arctangent of 2^-i in degrees * 65536, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_q16(input int unsigned i);
        logic signed [ACC_W-1:0] v;
        case (i)
            0:  v = ACC_W'(2949120);
            1:  v = ACC_W'(1740967);
            2:  v = ACC_W'(919879);
            3:  v = ACC_W'(466945);
            4:  v = ACC_W'(234379);
            5:  v = ACC_W'(117304);
            6:  v = ACC_W'(58666);
            7:  v = ACC_W'(29335);
            8:  v = ACC_W'(14668);
            9:  v = ACC_W'(7334);
            10: v = ACC_W'(3667);
            11: v = ACC_W'(1833);
            12: v = ACC_W'(917);
            13: v = ACC_W'(458);
            14: v = ACC_W'(229);
            15: v = ACC_W'(115);
            16: v = ACC_W'(57);
            17: v = ACC_W'(29);
            18: v = ACC_W'(14);
            19: v = ACC_W'(7);
            20: v = ACC_W'(4);
            21: v = ACC_W'(2);
            22: v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // one result bit of the integer square root
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t l);
        sqrt_lane_t  r;
        logic [26:0] rem_sh;
        logic [26:0] trial;
        rem_sh = {l.rem[24:0], l.n[47:46]};
        trial  = {1'b0, l.root, 2'b01};
        r.n    = {l.n[45:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {l.root[22:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {l.root[22:0], 1'b0};
        end
        return r;
    endfunction

    // one micro-rotation toward y = 0
    function automatic cd_lane_t cordic_step(input cd_lane_t l, input int unsigned i);
        cd_lane_t               r;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        dx = l.y >>> i;
        dy = l.x >>> i;
        if (!l.y[XY_W-1])
        begin
            r.x   = l.x + dx;
            r.y   = l.y - dy;
            r.acc = l.acc + atan_q16(i);
        end
        else
        begin
            r.x   = l.x - dx;
            r.y   = l.y + dy;
            r.acc = l.acc - atan_q16(i);
        end
        return r;
    endfunction

    // round to 8 fraction bits, clamp
    function automatic logic signed [ANG_W-1:0] finish_angle(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ANG_W-1:0] limit
    );
        logic signed [ACC_W-1:0] s;
        logic signed [ANG_W-1:0] a;
        s = acc + ACC_W'(128);
        a = s[ACC_W-1:8];
        if (a > limit)
            a = limit;
        else if (a < -limit)
            a = -limit;
        return a;
    endfunction

endpackage

// ===== hdl/tilt_and_heading_angles_top.sv =====
// Tilt and heading angles from one sensor sample.
//
// Command channel: drive accel_x/y/z and mag_x/y and raise start; the
// sample transfers at the rising edge where start is high and busy is low.
// busy stays low, so a new sample may transfer in every cycle.
// Result channel: pitch_deg, roll_deg and heading_deg (degrees * 256) sit
// on the ports for one cycle with done high; the receiver cannot stall.
// Throughput: one sample per cycle. The pipeline holds the 24-step square
// root (one result bit per stage) followed by one CORDIC micro-rotation per
// stage, plus a squaring stage, two load stages and an output register.
// Reset clears all valid bits; samples in flight are dropped and done
// stays low until new samples come through.
module tilt_and_heading_angles_top
    import tha_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    output logic               done,
    output logic signed [15:0] pitch_deg,
    output logic signed [15:0] roll_deg,
    output logic signed [16:0] heading_deg
);

    assign busy = 1'b0;

    // squaring stage
    logic              sqa_vld_reg;
    logic [30:0]       sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] ax_reg, ay_reg;
    cd_lane_t          head0_reg;
    logic              tzero0_reg, hzero0_reg;

    logic signed [31:0] px_next, py_next, pz_next;
    cd_lane_t           head0_next;
    logic signed [XY_W-1:0] mx_s, my_s;

    always_comb
    begin
        px_next = accel_x * accel_x;
        py_next = accel_y * accel_y;
        pz_next = accel_z * accel_z;
        mx_s = XY_W'(mag_x) <<< 8;
        my_s = XY_W'(mag_y) <<< 8;
        head0_next.x   = mx_s;
        head0_next.y   = my_s;
        head0_next.acc = '0;
        // move left half plane into the right one
        if (mag_x[15])
        begin
            if (!mag_y[15])
            begin
                head0_next.x   = my_s;
                head0_next.y   = -mx_s;
                head0_next.acc = DEG90_Q16;
            end
            else
            begin
                head0_next.x   = -my_s;
                head0_next.y   = mx_s;
                head0_next.acc = -DEG90_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqa_vld_reg <= 1'b0;
        else
            sqa_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        sqx_reg    <= px_next[30:0];
        sqy_reg    <= py_next[30:0];
        sqz_reg    <= pz_next[30:0];
        ax_reg     <= accel_x;
        ay_reg     <= accel_y;
        head0_reg  <= head0_next;
        tzero0_reg <= (accel_x == 16'sd0) && (accel_y == 16'sd0) && (accel_z == 16'sd0);
        hzero0_reg <= (mag_x == 16'sd0) && (mag_y == 16'sd0);
    end

    // square root stages
    sq_stage_t sq_reg [0:SQRT_STEPS];
    logic      sq_vld_reg [0:SQRT_STEPS];
    sq_stage_t sq0_next;
    logic [31:0] psum, rsum;

    always_comb
    begin
        psum = {1'b0, sqy_reg} + {1'b0, sqz_reg};
        rsum = {1'b0, sqx_reg} + {1'b0, sqz_reg};
        sq0_next.pitch.n    = {psum, 16'b0};
        sq0_next.pitch.rem  = '0;
        sq0_next.pitch.root = '0;
        sq0_next.roll.n     = {rsum, 16'b0};
        sq0_next.roll.rem   = '0;
        sq0_next.roll.root  = '0;
        sq0_next.ax         = ax_reg;
        sq0_next.ay         = ay_reg;
        sq0_next.head       = head0_reg;
        sq0_next.tilt_zero  = tzero0_reg;
        sq0_next.head_zero  = hzero0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else
            sq_vld_reg[0] <= sqa_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= sq0_next;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        sq_stage_t sq_next;
        always_comb
        begin
            sq_next       = sq_reg[k];
            sq_next.pitch = sqrt_step(sq_reg[k].pitch);
            sq_next.roll  = sqrt_step(sq_reg[k].roll);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end
        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sq_next;
        end
    end

    // CORDIC stages
    cd_stage_t cd_reg [0:CORDIC_STAGES];
    logic      cd_vld_reg [0:CORDIC_STAGES];
    cd_stage_t cd0_next;

    always_comb
    begin
        cd0_next.pitch.x   = XY_W'(sq_reg[SQRT_STEPS].pitch.root);
        cd0_next.pitch.y   = XY_W'(sq_reg[SQRT_STEPS].ax) <<< 8;
        cd0_next.pitch.acc = '0;
        cd0_next.roll.x    = XY_W'(sq_reg[SQRT_STEPS].roll.root);
        cd0_next.roll.y    = XY_W'(sq_reg[SQRT_STEPS].ay) <<< 8;
        cd0_next.roll.acc  = '0;
        cd0_next.head      = sq_reg[SQRT_STEPS].head;
        cd0_next.tilt_zero = sq_reg[SQRT_STEPS].tilt_zero;
        cd0_next.head_zero = sq_reg[SQRT_STEPS].head_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_vld_reg[0] <= 1'b0;
        else
            cd_vld_reg[0] <= sq_vld_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        cd_reg[0] <= cd0_next;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        cd_stage_t cd_next;
        always_comb
        begin
            cd_next       = cd_reg[i];
            cd_next.pitch = cordic_step(cd_reg[i].pitch, i);
            cd_next.roll  = cordic_step(cd_reg[i].roll, i);
            cd_next.head  = cordic_step(cd_reg[i].head, i);
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_vld_reg[i+1] <= 1'b0;
            else
                cd_vld_reg[i+1] <= cd_vld_reg[i];
        end
        always_ff @(posedge clk)
        begin
            cd_reg[i+1] <= cd_next;
        end
    end

    // output register
    logic                    done_reg;
    logic signed [15:0]      pitch_reg, roll_reg;
    logic signed [16:0]      head_reg;
    logic signed [ANG_W-1:0] pa, ra, ha;

    always_comb
    begin
        pa = finish_angle(cd_reg[CORDIC_STAGES].pitch.acc, TILT_LIMIT);
        ra = finish_angle(cd_reg[CORDIC_STAGES].roll.acc, TILT_LIMIT);
        ha = finish_angle(cd_reg[CORDIC_STAGES].head.acc, HEAD_LIMIT);
        if (cd_reg[CORDIC_STAGES].tilt_zero)
        begin
            pa = '0;
            ra = '0;
        end
        if (cd_reg[CORDIC_STAGES].head_zero)
            ha = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cd_vld_reg[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        pitch_reg <= pa[15:0];
        roll_reg  <= ra[15:0];
        head_reg  <= ha[16:0];
    end

    assign done        = done_reg;
    assign pitch_deg   = pitch_reg;
    assign roll_deg    = roll_reg;
    assign heading_deg = head_reg;

endmodule

// ===== hdl/tha_checker.sv =====
module tha_checker
    import tha_pkg::*;
#(
    parameter int LATENCY = CORDIC_STAGES_DEF + 28
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] pitch_deg,
    input logic signed [15:0] roll_deg,
    input logic signed [16:0] heading_deg
);

    // every result traces back to a transfer a fixed latency earlier
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching sample transfer");

    a_tilt_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_deg <= 16'sd23040) && (pitch_deg >= -16'sd23040)
              && (roll_deg <= 16'sd23040) && (roll_deg >= -16'sd23040))
        else $error("tilt angle out of range");

    a_head_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading_deg <= 17'sd46080) && (heading_deg >= -17'sd46080))
        else $error("heading out of range");

    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result right after reset");

endmodule

bind tilt_and_heading_angles_top tha_checker #(.LATENCY(CORDIC_STAGES + 28)) u_tha_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .pitch_deg   (pitch_deg),
    .roll_deg    (roll_deg),
    .heading_deg (heading_deg)
);

// ===== tb/tilt_and_heading_angles_top_test.sv =====
module tilt_and_heading_angles_top_test;

    import tha_pkg::*;

    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int LATENCY   = STAGES + 28;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 1530;
    localparam int TILT_MAX  = 23040;
    localparam int HEAD_MAX  = 46080;
    localparam longint RIGHT_ANGLE_Q16 = 5898240;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] mx;
        logic signed [15:0] my;
    } sample_t;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [16:0] heading;
    } angles_t;

    // directed row: sample, and whether the typed-in angles are checked too
    typedef struct {
        sample_t s;
        bit      known;
        angles_t a;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic               done;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
    logic signed [16:0] heading_deg;

    angles_t pending_angles[$];
    int      error_count;
    int      idle_cycles;
    bit      quiet_tail;

    tilt_and_heading_angles_top u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .mag_x       (mag_x),
        .mag_y       (mag_y),
        .done        (done),
        .pitch_deg   (pitch_deg),
        .roll_deg    (roll_deg),
        .heading_deg (heading_deg)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint arctan_step(int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    function automatic longint vector_angle(longint x, longint y, longint acc);
        longint dx;
        longint dy;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + arctan_step(i);
            end
            else
            begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - arctan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint round_clamp(longint acc, longint lim);
        longint a;
        a = (acc + 128) >>> 8;
        if (a > lim)
            a = lim;
        if (a < -lim)
            a = -lim;
        return a;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic longint tilt_of(longint num, longint p, longint q);
        longint den;
        den = int_sqrt(longint'(p * p + q * q) << 16);
        if (num == 0 && den == 0)
            return 0;
        return round_clamp(vector_angle(den, num * 256, 0), TILT_MAX);
    endfunction

    function automatic longint heading_of(longint mx, longint my);
        longint x;
        longint y;
        longint acc;
        x   = mx * 256;
        y   = my * 256;
        acc = 0;
        if (mx == 0 && my == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                x   = my * 256;
                y   = -mx * 256;
                acc = RIGHT_ANGLE_Q16;
            end
            else
            begin
                x   = -my * 256;
                y   = mx * 256;
                acc = -RIGHT_ANGLE_Q16;
            end
        end
        return round_clamp(vector_angle(x, y, acc), HEAD_MAX);
    endfunction

    function automatic angles_t predict_angles(sample_t s);
        angles_t a;
        a.pitch   = 16'(tilt_of(s.ax, s.ay, s.az));
        a.roll    = 16'(tilt_of(s.ay, s.ax, s.az));
        a.heading = 17'(heading_of(s.mx, s.my));
        return a;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // result side: check every strobe against the oldest expectation
    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
                report_mismatch("result with no sample outstanding");
            else
            begin
                e = pending_angles.pop_front();
                if (pitch_deg !== e.pitch)
                    report_mismatch($sformatf("pitch %0d, want %0d", pitch_deg, e.pitch));
                if (roll_deg !== e.roll)
                    report_mismatch($sformatf("roll %0d, want %0d", roll_deg, e.roll));
                if (heading_deg !== e.heading)
                    report_mismatch($sformatf("heading %0d, want %0d",
                                              heading_deg, e.heading));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tilt_and_heading_angles_top_test failed");
            $finish;
        end
    end

    // drive one sample; hold start until it transfers
    task automatic send_sample(sample_t s, angles_t e);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        accel_x <= s.ax;
        accel_y <= s.ay;
        accel_z <= s.az;
        mag_x   <= s.mx;
        mag_y   <= s.my;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_angles.push_back(e);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 8)) - 4);
            3: return 16'(signed'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        row_t    rows[$];
        row_t    r;
        sample_t s;
        angles_t e;

        error_count = 0;
        quiet_tail  = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        mag_x   = '0;
        mag_y   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all zero: every angle is zero
        rows.push_back('{'{0, 0, 0, 0, 0}, 1, '{0, 0, 0}});
        // only z: level, heading of an east vector is zero
        rows.push_back('{'{0, 0, 1000, 1000, 0}, 1, '{0, 0, 0}});
        // axes pointing straight up the tilt axis, clamped at the extremes; then mixed samples
        rows.push_back('{'{16'sh7FFF, 0, 0, 0, 16'sh7FFF}, 0, '{0, 0, 0}});
        rows.push_back('{'{16'sh8000, 0, 0, 0, 16'sh8000}, 0, '{0, 0, 0}});
        rows.push_back('{'{0, 16'sh7FFF, 0, 16'sh8000, 0}, 0, '{0, 0, 0}});
        rows.push_back('{'{0, 16'sh8000, 0, 16'sh8000, 16'sh8000}, 0, '{0, 0, 0}});
        rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF},
                        0, '{0, 0, 0}});
        rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                        0, '{0, 0, 0}});
        rows.push_back('{'{-1, 1, -1, -1, -1}, 0, '{0, 0, 0}});
        rows.push_back('{'{1, -1, 0, -1, 1}, 0, '{0, 0, 0}});
        rows.push_back('{'{100, 200, -300, 0, -5}, 0, '{0, 0, 0}});
        rows.push_back('{'{-5000, 12000, 20000, -7, 0}, 0, '{0, 0, 0}});
        rows.push_back('{'{0, 0, 16'sh8000, 16'sh7FFF, 16'sh8000}, 0, '{0, 0, 0}});

        foreach (rows[i])
        begin
            r = rows[i];
            e = predict_angles(r.s);
            if (r.known && (e.pitch !== r.a.pitch || e.roll !== r.a.roll ||
                            e.heading !== r.a.heading))
                report_mismatch($sformatf("directed row %0d disagrees with typed angles", i));
            send_sample(r.s, r.known ? r.a : e);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                start <= 1'b0;
                while (pending_angles.size() != 0)
                    @(negedge clk);
            end
            if (n == N_RANDOM - 200)
                quiet_tail = 1'b1;
            s.ax = pick_axis();
            s.ay = pick_axis();
            s.az = pick_axis();
            s.mx = pick_axis();
            s.my = pick_axis();
            send_sample(s, predict_angles(s));
        end
        start <= 1'b0;

        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);

        if (error_count == 0)
            $display("tilt_and_heading_angles_top_test passed");
        else
            $display("tilt_and_heading_angles_top_test failed");
        $finish;
    end

endmodule
